/* design/ptpa_pkg.sv */
// Package: widths, CORDIC angle table and shared types for the pointing-angle core.
`default_nettype none
package ptpa_pkg;
	localparam int CordicIterations = 16;
	localparam int CW = 40;
	localparam int ZW = 26;
	localparam int HalfTurn = 23040;
	localparam int FullTurn = 46080;
	localparam int StepLimit = 46080;
	localparam logic signed [ZW-1:0] Deg90Q16 = 26'sd5898240;

	typedef enum logic [2:0] {
		REG_BASE_X = 3'd0, REG_BASE_Y = 3'd1, REG_BASE_Z = 3'd2, REG_BASE_YAW = 3'd3,
		REG_BASE_PITCH = 3'd4, REG_PAN_SPD = 3'd5, REG_TILT_SPD = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic zero;
	} cordic_t;

	function automatic logic signed [ZW-1:0] atan_step(input int i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				0: r = 26'sd2949120; 1: r = 26'sd1740967; 2: r = 26'sd919879;
				3: r = 26'sd466945; 4: r = 26'sd234379; 5: r = 26'sd117265;
				6: r = 26'sd58666; 7: r = 26'sd29335; 8: r = 26'sd14668;
				9: r = 26'sd7334; 10: r = 26'sd3667; 11: r = 26'sd1833;
				12: r = 26'sd917; 13: r = 26'sd458; 14: r = 26'sd229;
				15: r = 26'sd115; 16: r = 26'sd57; 17: r = 26'sd29;
				18: r = 26'sd14; 19: r = 26'sd7; 20: r = 26'sd4;
				21: r = 26'sd2; 22: r = 26'sd1;
				default: r = '0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

/* design/ptpa_isqrt.sv */
// Pipelined floor integer square root, one result bit per step, registered after every fourth step.
`default_nettype none
module ptpa_isqrt import ptpa_pkg::*; (
	input wire logic clk,
	input wire logic en,
	input wire logic [63:0] n,
	output logic [31:0] root
);
	logic [63:0] rem_s [0:32];
	logic [31:0] res_s [0:32];
	always_comb begin
		rem_s[0] = n;
		res_s[0] = '0;
	end
	for (genvar k = 0; k < 32; k++) begin : g_st
		logic [65:0] trial;
		logic [63:0] rem_n;
		logic [31:0] res_n;
		always_comb begin
			trial = {2'b00, rem_s[k] >> (2 * (31 - k))};
			if (trial >= {32'd0, res_s[k], 2'b01}) begin
				rem_n = rem_s[k] - ({30'd0, res_s[k], 2'b01} << (2 * (31 - k)));
				res_n = {res_s[k][30:0], 1'b1};
			end else begin
				rem_n = rem_s[k];
				res_n = {res_s[k][30:0], 1'b0};
			end
		end
		if (k % 4 == 3) begin : g_reg
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= rem_n;
					res_s[k+1] <= res_n;
				end
			end
		end else begin : g_cmb
			always_comb begin
				rem_s[k+1] = rem_n;
				res_s[k+1] = res_n;
			end
		end
	end
	assign root = res_s[32];
endmodule
`default_nettype wire

/* design/ptpa_cordic.sv */
// Pipelined vectoring CORDIC atan2, result in 1/128 degree.
`default_nettype none
module ptpa_cordic import ptpa_pkg::*; (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [CW-1:0] y_in,
	input wire logic signed [CW-1:0] x_in,
	output logic signed [15:0] angle
);
	cordic_t st [0:CordicIterations];
	cordic_t pre;
	logic signed [ZW-1:0] zr;
	always_comb begin
		pre.zero = (x_in == '0) && (y_in == '0);
		pre.x = x_in;
		pre.y = y_in;
		pre.z = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				pre.x = y_in; pre.y = -x_in; pre.z = Deg90Q16;
			end else begin
				pre.x = -y_in; pre.y = x_in; pre.z = -Deg90Q16;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en) st[0] <= pre;
	end
	for (genvar i = 0; i < CordicIterations; i++) begin : g_it
		cordic_t nx;
		always_comb begin
			nx = st[i];
			if (st[i].y >= 0) begin
				nx.x = st[i].x + (st[i].y >>> i);
				nx.y = st[i].y - (st[i].x >>> i);
				nx.z = st[i].z + atan_step(i);
			end else begin
				nx.x = st[i].x - (st[i].y >>> i);
				nx.y = st[i].y + (st[i].x >>> i);
				nx.z = st[i].z - atan_step(i);
			end
		end
		if (i % 2 == 1) begin : g_reg
			always_ff @(posedge clk) begin
				if (en) st[i+1] <= nx;
			end
		end else begin : g_cmb
			assign st[i+1] = nx;
		end
	end
	if (CordicIterations % 2 == 1) begin : g_odd
	end
	always_comb begin
		zr = (st[CordicIterations].z + ZW'(256)) >>> 9;
		angle = st[CordicIterations].zero ? 16'sd0 : 16'(zr);
	end
endmodule
`default_nettype wire

/* design/pan_tilt_pointing_angles_core.sv */
// Top level: pan/tilt pointing angles from target and base positions.
// Throughput: one item per cycle; the pipeline advances whenever the output
// register is empty or taken, and all stages stall together otherwise.
// Reset: asynchronous active low; clears valid bits and config registers.
`default_nettype none
module pan_tilt_pointing_angles_core import ptpa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [95:0] s_axis_tdata, // target_x, target_y, target_z
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [71:0] m_axis_tdata, // pan_angle, tilt_angle, pan_steps, tilt_steps, pad
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int Lat = 14 + CordicIterations / 2;
	logic signed [31:0] base_x_q, base_y_q, base_z_q;
	logic signed [15:0] base_yaw_q;
	logic signed [14:0] base_pitch_q;
	logic [15:0] pan_spd_q, tilt_spd_q;
	logic [Lat-1:0] vld_q;
	logic en;
	assign cfg_ready = 1'b1;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q <= '0; base_y_q <= '0; base_z_q <= '0;
			base_yaw_q <= '0; base_pitch_q <= '0; pan_spd_q <= '0; tilt_spd_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BASE_X: base_x_q <= cfg_data;
				REG_BASE_Y: base_y_q <= cfg_data;
				REG_BASE_Z: base_z_q <= cfg_data;
				REG_BASE_YAW: base_yaw_q <= cfg_data[15:0];
				REG_BASE_PITCH: base_pitch_q <= cfg_data[14:0];
				REG_PAN_SPD: pan_spd_q <= cfg_data[15:0];
				REG_TILT_SPD: tilt_spd_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// stage 1: differences
	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 33'(signed'(s_axis_tdata[31:0])) - 33'(base_x_q);
			dy_s1 <= 33'(signed'(s_axis_tdata[63:32])) - 33'(base_y_q);
			dz_s1 <= 33'(signed'(s_axis_tdata[95:64])) - 33'(base_z_q);
		end
	end
	// stage 2: halving and magnitudes, squared in stage 3
	logic [32:0] ax, az, ay;
	logic big;
	logic signed [32:0] hx, hy, hz;
	always_comb begin
		ax = dx_s1[32] ? 33'(-dx_s1) : dx_s1;
		ay = dy_s1[32] ? 33'(-dy_s1) : dy_s1;
		az = dz_s1[32] ? 33'(-dz_s1) : dz_s1;
		big = (ax > 33'h80000000) || (ay > 33'h80000000) || (az > 33'h80000000);
		hx = big ? dx_s1 >>> 1 : dx_s1;
		hy = big ? dy_s1 >>> 1 : dy_s1;
		hz = big ? dz_s1 >>> 1 : dz_s1;
	end
	logic [32:0] mx_s2, mz_s2;
	logic signed [32:0] hy_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2 <= hx[32] ? 33'(-hx) : hx;
			mz_s2 <= hz[32] ? 33'(-hz) : hz;
			hy_s2 <= hy;
		end
	end
	logic [63:0] sq_s3;
	logic signed [32:0] hy_d [0:8];
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3 <= 64'(mx_s2[31:0]) * 64'(mx_s2[31:0]) + 64'(mz_s2[31:0]) * 64'(mz_s2[31:0])
				+ (mx_s2[32] ? 64'h4000000000000000 : 64'd0)
				+ (mz_s2[32] ? 64'h4000000000000000 : 64'd0);
			hy_d[0] <= hy_s2;
			for (int k = 0; k < 8; k++) hy_d[k+1] <= hy_d[k];
		end
	end
	logic [31:0] root;
	ptpa_isqrt u_sqrt (.clk, .en, .n(sq_s3), .root);
	// root is registered through the square-root pipeline; hy_d[8] aligned with it
	logic signed [15:0] tilt_raw, pan_raw;
	ptpa_cordic u_tilt (.clk, .en, .y_in(CW'(hy_d[8])), .x_in(CW'({1'b0, root})),
		.angle(tilt_raw));
	// pan path delayed to match tilt
	logic signed [32:0] px_d [0:9], pz_d [0:9];
	always_ff @(posedge clk) begin
		if (en) begin
			px_d[0] <= -dx_s1;
			pz_d[0] <= -dz_s1;
			for (int k = 0; k < 9; k++) begin
				px_d[k+1] <= px_d[k];
				pz_d[k+1] <= pz_d[k];
			end
		end
	end
	ptpa_cordic u_pan (.clk, .en, .y_in(CW'(px_d[9])), .x_in(CW'(pz_d[9])),
		.angle(pan_raw));
	// stage: subtract offsets, wrap, saturate
	logic signed [17:0] pan_w, tilt_w;
	logic signed [15:0] pan_a, tilt_a;
	logic signed [15:0] pan_s1, tilt_s1;
	always_comb begin
		pan_w = 18'(pan_raw) - 18'(base_yaw_q);
		if (pan_w > 18'sd23040) pan_w = pan_w - 18'sd46080;
		else if (pan_w <= -18'sd23040) pan_w = pan_w + 18'sd46080;
		if (pan_w > 18'sd23040) pan_w = pan_w - 18'sd46080;
		else if (pan_w <= -18'sd23040) pan_w = pan_w + 18'sd46080;
		pan_a = 16'(pan_w);
		tilt_w = 18'(tilt_raw) - 18'(base_pitch_q);
		if (tilt_w > 18'sd23040) tilt_w = 18'sd23040;
		if (tilt_w < -18'sd23040) tilt_w = -18'sd23040;
		tilt_a = 16'(tilt_w);
	end
	logic signed [33:0] pp_s2, tp_s2;
	logic signed [15:0] pan_s2, tilt_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			pan_s1 <= pan_a;
			tilt_s1 <= tilt_a;
			pp_s2 <= -(34'(pan_s1) * 34'(signed'({1'b0, pan_spd_q})));
			tp_s2 <= -(34'(tilt_s1) * 34'(signed'({1'b0, tilt_spd_q})));
			pan_s2 <= pan_s1;
			tilt_s2 <= tilt_s1;
		end
	end
	function automatic logic signed [16:0] rsat(input logic signed [33:0] p);
		logic [33:0] m;
		logic [33:0] r;
		begin
			m = p[33] ? 34'(-p) : p;
			r = (m + 34'd16384) >> 15;
			if (r > 34'(StepLimit)) r = 34'(StepLimit);
			return p[33] ? 17'(-signed'(r)) : 17'(r);
		end
	endfunction
	logic [71:0] out_q;
	always_ff @(posedge clk) begin
		if (en) out_q <= {6'd0, rsat(tp_s2), rsat(pp_s2), tilt_s2, pan_s2};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= vld_q[Lat-1];
	end
	assign m_axis_tdata = out_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_q))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready mismatch");
	a_pan_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(out_q[15:0]) <= 23040 && $signed(out_q[15:0]) > -23040))
		else $error("pan out of range");
endmodule
`default_nettype wire

/* bench/pan_tilt_pointing_angles_core_tb.sv */
// Testbench for the pan/tilt pointing-angle core: directed and random targets checked against a local predictor.
module pan_tilt_pointing_angles_core_tb import ptpa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] pan;
		logic signed [15:0] tilt;
		logic signed [16:0] pan_steps;
		logic signed [16:0] tilt_steps;
	} angles_t;

	typedef struct {
		logic [31:0] tx, ty, tz;
		bit chk;
		angles_t ang;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic signed [31:0] bx, by, bz;
	logic signed [15:0] yaw;
	logic signed [14:0] pitch;
	logic [15:0] pan_spd, tilt_spd;

	angles_t pending_angles[$];
	int errors = 0;
	bit hold_off = 0;

	pan_tilt_pointing_angles_core u_top (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan2_deg128(longint y, longint x);
		longint z, t, xs, ys, a;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 5898240;
			end else begin
				t = x; x = -y; y = t; z = -5898240;
			end
		end
		for (int i = 0; i < CordicIterations; i++) begin
			xs = shr(x, i);
			ys = shr(y, i);
			a = (i < 32) ? longint'(atan_tab(i)) : 0;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += a;
			end else begin
				x = x - ys; y = y + xs; z -= a;
			end
		end
		return shr(z + 256, 9);
	endfunction

	function automatic longint atan_tab(int i);
		longint t[32] = '{2949120, 1740967, 919879, 466945, 234379, 117265, 58666, 29335,
			14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0,
			0, 0, 0, 0, 0, 0, 0, 0};
		return t[i];
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned absv(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint angle_to_steps(longint ang, logic [15:0] sc);
		longint p, r;
		p = -ang * longint'({1'b0, sc});
		r = longint'((absv(p) + 16384) >> 15);
		if (p < 0)
			r = -r;
		if (r > StepLimit) r = StepLimit;
		if (r < -StepLimit) r = -StepLimit;
		return r;
	endfunction

	function automatic angles_t aim_angles(logic [31:0] tx, ty, tz);
		longint dx, dy, dz, pan, tilt, hx, hy, hz, h;
		longint unsigned lim;
		angles_t o;
		dx = longint'($signed(tx)) - longint'(bx);
		dy = longint'($signed(ty)) - longint'(by);
		dz = longint'($signed(tz)) - longint'(bz);
		lim = 64'd1 << 31;
		pan = atan2_deg128(-dx, -dz) - longint'(yaw);
		while (pan > HalfTurn) pan -= FullTurn;
		while (pan <= -HalfTurn) pan += FullTurn;
		hx = dx; hy = dy; hz = dz;
		if (absv(hx) > lim || absv(hy) > lim || absv(hz) > lim) begin
			hx = shr(hx, 1); hy = shr(hy, 1); hz = shr(hz, 1);
		end
		h = longint'(floor_sqrt(absv(hx) * absv(hx) + absv(hz) * absv(hz)));
		tilt = atan2_deg128(hy, h) - longint'(pitch);
		if (tilt > HalfTurn) tilt = HalfTurn;
		if (tilt < -HalfTurn) tilt = -HalfTurn;
		o.pan = pan[15:0];
		o.tilt = tilt[15:0];
		o.pan_steps = 17'(angle_to_steps(pan, pan_spd));
		o.tilt_steps = 17'(angle_to_steps(tilt, tilt_spd));
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	// valid stays high until the caller drops it after its last write
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_BASE_X: bx = val;
			REG_BASE_Y: by = val;
			REG_BASE_Z: bz = val;
			REG_BASE_YAW: yaw = val[15:0];
			REG_BASE_PITCH: pitch = val[14:0];
			REG_PAN_SPD: pan_spd = val[15:0];
			REG_TILT_SPD: tilt_spd = val[15:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		int n;
		n = 0;
		while (pending_angles.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (40) @(posedge clk);
	endtask

	// one target transfer; a gap may open before a new burst
	int burst_left = 0;
	task automatic send_target(logic [31:0] tx, ty, tz, bit chk, angles_t want);
		angles_t a;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {tz, ty, tx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		a = aim_angles(tx, ty, tz);
		if (chk) begin
			if (a.pan !== want.pan || a.tilt !== want.tilt
				|| a.pan_steps !== want.pan_steps || a.tilt_steps !== want.tilt_steps)
				report_mismatch("directed row vs predictor", a.pan, want.pan);
		end
		pending_angles.push_back(a);
		burst_left--;
	endtask

	task automatic finish_burst();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 4000)) : -32'($urandom_range(0, 4000));
			3: return $urandom_range(0, 1) ? 32'($urandom_range(0, 100) << 16)
				: -32'($urandom_range(0, 100) << 16);
			default: return $urandom;
		endcase
	endfunction

	// receiver stall pattern, plus one long hold-off
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_off)
				m_axis_tready <= 1'b0;
			else begin
				phase = (phase + 1) % 23;
				m_axis_tready <= (phase < 9) ? 1'b1 : ($urandom_range(0, 2) != 0);
			end
		end
	end

	initial begin
		angles_t got, want;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.pan = m_axis_tdata[15:0];
				got.tilt = m_axis_tdata[31:16];
				got.pan_steps = m_axis_tdata[48:32];
				got.tilt_steps = m_axis_tdata[65:49];
				if (pending_angles.size() == 0)
					report_mismatch("unexpected result", got.pan, 0);
				else begin
					want = pending_angles.pop_front();
					if (got.pan !== want.pan) report_mismatch("pan_angle", got.pan, want.pan);
					if (got.tilt !== want.tilt)
						report_mismatch("tilt_angle", got.tilt, want.tilt);
					if (got.pan_steps !== want.pan_steps)
						report_mismatch("pan_steps", got.pan_steps, want.pan_steps);
					if (got.tilt_steps !== want.tilt_steps)
						report_mismatch("tilt_steps", got.tilt_steps, want.tilt_steps);
				end
			end
		end
	end

	row_t rows[$];
	angles_t z0;

	initial begin
		logic [31:0] cfgs[4][7];
		bx = 0; by = 0; bz = 0; yaw = 0; pitch = 0; pan_spd = 0; tilt_spd = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: zero vector, all angles zero
		z0 = '{0, 0, 0, 0};
		rows.push_back('{0, 0, 0, 1, z0});
		rows.push_back('{32'h0001_0000, 0, 0, 0, z0});
		rows.push_back('{0, 32'h0001_0000, 0, 0, z0});
		rows.push_back('{0, 32'hffff_0000, 0, 0, z0});
		rows.push_back('{0, 0, 32'hffff_0000, 0, z0});
		rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, z0});
		rows.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, z0});
		rows.push_back('{32'hffff_ffff, 0, 0, 0, z0});
		rows.push_back('{0, 0, 32'h0000_0001, 0, z0});
		foreach (rows[i])
			send_target(rows[i].tx, rows[i].ty, rows[i].tz, rows[i].chk, rows[i].ang);
		finish_burst();
		wait_drained();

		// extremes: opposite corners make 33-bit differences and halve tilt operands
		cfgs[0] = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd23040,
			32'(-11520), 32'hffff, 32'hffff};
		cfgs[1] = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'(-23040),
			32'd11520, 32'd0, 32'h0100};
		cfgs[2] = '{0, 0, 0, 32'h7fff, 32'h3fff, 32'h0080, 32'hffff};
		cfgs[3] = '{0, 0, 0, 32'h8000, 32'h4000, 32'h0100, 32'h0001};
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 7; r++)
				write_reg(reg_idx_t'(r), cfgs[c][r]);
			cfg_valid <= 1'b0;
			send_target(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, z0);
			send_target(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, z0);
			send_target(bx, by, bz, 0, z0);
			send_target(bx, by + 32'h10000, bz, 0, z0);
			finish_burst();
			wait_drained();
		end

		// random phases with random settings
		for (int ph = 0; ph < 8; ph++) begin
			for (int r = 0; r < 7; r++) begin
				logic [31:0] v;
				case (r)
					3: v = 32'($signed($urandom_range(0, 46080)) - 23040);
					4: v = 32'($signed($urandom_range(0, 23040)) - 11520);
					5, 6: v = $urandom_range(0, 65535);
					default: v = ($urandom_range(0, 2) == 0) ? $urandom
						: 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
				endcase
				write_reg(reg_idx_t'(r), v);
			end
			cfg_valid <= 1'b0;
			if (ph == 3)
				fork
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
				join_none
			for (int k = 0; k < 210; k++)
				send_target(rand_coord(), rand_coord(), rand_coord(), 0, z0);
			finish_burst();
			wait_drained();
		end

		if (pending_angles.size() != 0)
			report_mismatch("results missing", pending_angles.size(), 0);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
